FILE: src/fbba_pkg.sv
// Shared constants, payload types and helpers for the free block bitmap allocator.
`default_nettype none
package fbba_pkg;

  localparam int NUM_BLOCKS = 512;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W      = 9;
  localparam int LAST_BITS  = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;

  localparam logic [WADDR_W-1:0]   LAST_WORD = WADDR_W'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    (LAST_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}} :
    WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_TEST      = 3'd2;
  localparam logic [2:0] OP_ALLOC     = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]       func;
    logic [IDX_W-1:0] blk_idx;
  } fbba_in_t;

  typedef struct packed {
    logic             prior_bit;
    logic [IDX_W-1:0] found_index;
    logic [1:0]       status;
  } fbba_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_DONE
  } fbba_state_t;

  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/fbba_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module fbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/free_block_bitmap_allocator_core.sv
// Flow: mark, free and test pass through read-modify-write and done before the result is
// registered; range errors, unknown operations, clear all and an allocate whose start is
// out of range go straight to done; allocate otherwise reads n words (1 to 16) from the
// bitmap RAM, one per cycle, before done. Done holds while the output is stalled.
// One item at a time: the next transfer is taken once the result is registered.
// Reset: per-word valid flags clear the bitmap at once, no clearing sweep; start is 2.
`default_nettype none
module free_block_bitmap_allocator_core
  import fbba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire fbba_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output fbba_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [IDX_W-1:0] cfg_wdata
);

  fbba_state_t          state_r, state_nxt;
  fbba_in_t             req_r, req_nxt;
  fbba_out_t            res_r, res_nxt;
  fbba_out_t            out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WADDR_W-1:0]   waddr_r, waddr_nxt;
  logic                 first_r, first_nxt;
  logic [MAP_WORDS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]     start_r;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_cur;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     free_pos;
  logic [BIT_W-1:0]     req_pos;
  logic [BIT_W-1:0]     start_pos;

  fbba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_r),
    .wdata(ram_wdata),
    .raddr(waddr_nxt),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign word_cur  = valid_r[waddr_r] ? ram_rdata : '0;
  assign req_pos   = req_r.blk_idx[BIT_W-1:0];
  assign start_pos = start_r[BIT_W-1:0];
  assign lo_mask   = first_r ? ~((WORD_BITS'(1) << start_pos) - WORD_BITS'(1)) : '1;
  assign hi_mask   = (waddr_r == LAST_WORD) ? LAST_MASK : '1;
  assign free_bits = ~word_cur & lo_mask & hi_mask;
  assign free_pos  = first_set(free_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      first_r     <= 1'b0;
      start_r     <= IDX_W'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      first_r     <= first_nxt;
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    waddr_r    <= waddr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    waddr_nxt     = waddr_r;
    first_nxt     = first_r;
    valid_nxt     = valid_r;
    ram_we        = 1'b0;
    ram_wdata     = word_cur;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          unique case (in_data.func) inside
            OP_SET, OP_CLEAR, OP_TEST: begin
              if (32'(in_data.blk_idx) >= NUM_BLOCKS) begin
                res_nxt.status = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                waddr_nxt = WADDR_W'(in_data.blk_idx >> BIT_W);
                state_nxt = S_RMW;
              end
            end
            OP_ALLOC: begin
              if (32'(start_r) >= NUM_BLOCKS) begin
                res_nxt.status = ST_NONE;
                state_nxt      = S_DONE;
              end else begin
                waddr_nxt = WADDR_W'(start_r >> BIT_W);
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR_ALL: begin
              valid_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RMW: begin
        res_nxt.prior_bit = word_cur[req_pos];
        if (req_r.func == OP_SET) begin
          ram_we    = 1'b1;
          ram_wdata = word_cur | (WORD_BITS'(1) << req_pos);
        end else if (req_r.func == OP_CLEAR) begin
          ram_we    = 1'b1;
          ram_wdata = word_cur & ~(WORD_BITS'(1) << req_pos);
        end
        if (ram_we) begin
          valid_nxt[waddr_r] = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        first_nxt = 1'b0;
        if (|free_bits) begin
          ram_we              = 1'b1;
          ram_wdata           = word_cur | (WORD_BITS'(1) << free_pos);
          valid_nxt[waddr_r]  = 1'b1;
          res_nxt.found_index = IDX_W'({waddr_r, free_pos});
          res_nxt.status      = ST_OK;
          state_nxt           = S_DONE;
        end else if (waddr_r == LAST_WORD) begin
          res_nxt.status = ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          waddr_nxt = waddr_r + WADDR_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("result not registered on completion");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_RMW || state_r == S_SCAN))
    else $error("bitmap write outside read-modify-write");

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.found_index == '0 && !out_data_r.prior_bit))
    else $error("failed request carries data");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_free_block_bitmap_allocator_core.sv
// Self-checking testbench for the free block bitmap allocator core.
`timescale 1ns / 1ps
module tb_free_block_bitmap_allocator_core
  import fbba_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 250;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [IDX_W-1:0] START_AT_RESET = IDX_W'(2);
  localparam logic [IDX_W-1:0] TOP_BLOCK      = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  class alloc_tracker;
    bit [NUM_BLOCKS-1:0] used_map;
    logic [IDX_W-1:0]    alloc_floor;
    fbba_out_t           pending_replies[$];
    int errors;
    int replies_checked;
    int grants;
    int exhausted;

    function new();
      used_map        = '0;
      alloc_floor     = START_AT_RESET;
      errors          = 0;
      replies_checked = 0;
      grants          = 0;
      exhausted       = 0;
    endfunction

    function void set_floor(input logic [IDX_W-1:0] v);
      alloc_floor = v;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void note_request(input fbba_in_t req);
      fbba_out_t rep;
      int b;
      bit hit;
      rep = '0;
      rep.status = ST_OK;
      case (req.func) inside
        OP_SET, OP_CLEAR, OP_TEST: begin
          if (int'(req.blk_idx) >= NUM_BLOCKS) begin
            rep.status = ST_RANGE;
          end else begin
            rep.prior_bit = used_map[req.blk_idx];
            if (req.func == OP_SET) used_map[req.blk_idx] = 1'b1;
            else if (req.func == OP_CLEAR) used_map[req.blk_idx] = 1'b0;
          end
        end
        OP_ALLOC: begin
          rep.status = ST_NONE;
          hit = 1'b0;
          b = int'(alloc_floor);
          while (!hit && b < NUM_BLOCKS) begin
            if (!used_map[b]) begin
              hit = 1'b1;
              used_map[b] = 1'b1;
              rep.found_index = IDX_W'(b);
              rep.status = ST_OK;
            end
            b++;
          end
          if (hit) grants++;
          else exhausted++;
        end
        OP_CLEAR_ALL: used_map = '0;
        default: ;
      endcase
      pending_replies.push_back(rep);
    endfunction

    function void check_reply(input fbba_out_t got);
      fbba_out_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: %h", got);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (got.prior_bit !== want.prior_bit) begin
          $error("prior_bit: expected %0d, got %0d", want.prior_bit, got.prior_bit);
          errors++;
        end
        if (got.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  fbba_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  fbba_out_t        out_data;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;

  alloc_tracker sb;
  int sent_count;
  int replies_seen;
  int burst_left;
  int starts_tried;
  int idle_cycles;

  free_block_bitmap_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic fbba_in_t make_req(input logic [2:0] f, input logic [IDX_W-1:0] idx);
    fbba_in_t r;
    r.func    = f;
    r.blk_idx = idx;
    return r;
  endfunction

  function automatic fbba_in_t random_req(input logic [IDX_W-1:0] floor);
    int pick;
    logic [2:0] f;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 35) f = OP_ALLOC;
    else if (pick < 55) f = OP_SET;
    else if (pick < 75) f = OP_CLEAR;
    else if (pick < 92) f = OP_TEST;
    else if (pick < 94) f = OP_CLEAR_ALL;
    else f = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    // bias indices towards the allocation floor so frees feed later allocations
    if ($urandom_range(0, 1) != 0) idx = floor + IDX_W'($urandom_range(0, 63));
    else idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    return make_req(f, idx);
  endfunction

  task automatic send_request(input fbba_in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 9) >= 3) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic write_start(input logic [IDX_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_floor(v);
    starts_tried++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_reply(out_data);
      replies_seen++;
    end
  end

  // receiver: segments of steady, light or heavy back-pressure, plus one long hold-off
  initial begin : receiver
    int seg_len;
    int mode;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && replies_seen >= 300) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      seg_len = $urandom_range(5, 60);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) != 0);
          2: out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [IDX_W-1:0] floor;
    sb           = new();
    sent_count   = 0;
    replies_seen = 0;
    burst_left   = 0;
    starts_tried = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(make_req(OP_TEST, '0));
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_ALLOC, TOP_BLOCK));
    send_request(make_req(OP_SET, START_AT_RESET));
    send_request(make_req(OP_SET, '0));
    send_request(make_req(OP_TEST, '0));
    send_request(make_req(OP_SET, TOP_BLOCK));
    send_request(make_req(OP_TEST, TOP_BLOCK));
    send_request(make_req(OP_CLEAR, TOP_BLOCK));
    send_request(make_req(OP_CLEAR, TOP_BLOCK));
    send_request(make_req(OP_SPARE_5, TOP_BLOCK));
    send_request(make_req(OP_SPARE_6, '0));
    send_request(make_req(OP_SPARE_7, IDX_W'(9'h0AA)));
    send_request(make_req(OP_CLEAR_ALL, IDX_W'(9'h155)));
    send_request(make_req(OP_TEST, '0));
    send_request(make_req(OP_ALLOC, '0));

    write_start(TOP_BLOCK);
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_TEST, TOP_BLOCK));

    write_start('0);
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_CLEAR, '0));
    send_request(make_req(OP_ALLOC, '0));

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) floor = '0;
      else if (p == 1) floor = TOP_BLOCK;
      else if (p % 2 == 0) floor = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
      else floor = IDX_W'($urandom_range(NUM_BLOCKS - 64, NUM_BLOCKS - 1));
      write_start(floor);
      repeat (PHASE_ITEMS) send_request(random_req(floor));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d replies never arrived", sb.pending());
      sb.errors++;
    end
    $display("Covered %0d requests and %0d replies over %0d allocation floors.",
             sent_count, sb.replies_checked, starts_tried);
    $display("Allocations granted: %0d, refused with nothing free: %0d.",
             sb.grants, sb.exhausted);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
